FILE: hdl/int_literal_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer literal parser unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INT_LITERAL_PARSER_UNIT_MACROS_SVH
`define INT_LITERAL_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge
`define ILP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilp check failed");

// Next-cycle implication, sampled on the rising clock edge
`define ILP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilp check failed");

`else

`define ILP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ILP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Shared constants and types for the integer literal parser unit.
// ----------------------------------------------------------------------------
package ilp_pkg;

    // Character codes
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_LC_A       = 8'h61;
    localparam logic [7:0] CHAR_LC_F       = 8'h66;
    localparam logic [7:0] CHAR_UC_A       = 8'h41;
    localparam logic [7:0] CHAR_UC_F       = 8'h46;
    localparam logic [7:0] CHAR_B          = 8'h62;
    localparam logic [7:0] CHAR_O          = 8'h6f;
    localparam logic [7:0] CHAR_X          = 8'h78;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CHAR_I          = 8'h69;
    localparam logic [7:0] CHAR_3          = 8'h33;
    localparam logic [7:0] CHAR_2          = 8'h32;

    // Radix codes
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_BIN = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    // Suffix progress codes
    localparam logic [1:0] SUFFIX_NONE = 2'd0;
    localparam logic [1:0] SUFFIX_I    = 2'd1;
    localparam logic [1:0] SUFFIX_I3   = 2'd2;
    localparam logic [1:0] SUFFIX_FULL = 2'd3;

    // Character position counter saturates here
    localparam logic [1:0] CHAR_INDEX_SAT = 2'd2;

    // Widths
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 31;
    localparam int SCALED_W = VALUE_W + 4;
    localparam int NEXT_W   = SCALED_W + 1;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Classified character, front to back
    typedef struct packed {
        logic       present;
        logic       last;
        logic       is_zero;
        logic       is_prefix;
        logic [1:0] prefix_radix;
        logic       is_underscore;
        logic       digit_ok;
        logic [3:0] digit;
        logic [2:0] suffix_hit;   // bit k: matches k-th character of "i32"
    } t_cls;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
    } t_queue_status;

endpackage

FILE: hdl/ilp_front.sv
// ----------------------------------------------------------------------------
// ilp_front
// Accepts characters and classifies them into digit, prefix, underscore and
// suffix classes before they enter the queue.
// ----------------------------------------------------------------------------
module ilp_front (
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [ilp_pkg::CHAR_W-1:0] i_char_code,
    input  logic                      i_char_present,
    input  logic                      i_is_last,
    input  ilp_pkg::t_queue_status    i_queue_status,
    output logic                      o_push,
    output ilp_pkg::t_cls             o_cls
);

    logic is_dec;
    logic is_lc_hex;
    logic is_uc_hex;

    // Hold the input whenever the queue has no room
    assign o_stall = i_queue_status.full;
    assign o_push  = i_valid & ~i_queue_status.full;

    // Digit ranges
    assign is_dec    = (i_char_code >= ilp_pkg::CHAR_ZERO) && (i_char_code <= ilp_pkg::CHAR_NINE);
    assign is_lc_hex = (i_char_code >= ilp_pkg::CHAR_LC_A) && (i_char_code <= ilp_pkg::CHAR_LC_F);
    assign is_uc_hex = (i_char_code >= ilp_pkg::CHAR_UC_A) && (i_char_code <= ilp_pkg::CHAR_UC_F);

    // Classify the character
    always_comb begin
        o_cls               = '0;
        o_cls.present       = i_char_present;
        o_cls.last          = i_is_last;
        o_cls.is_zero       = (i_char_code == ilp_pkg::CHAR_ZERO);
        o_cls.is_underscore = (i_char_code == ilp_pkg::CHAR_UNDERSCORE);
        o_cls.digit_ok      = is_dec | is_lc_hex | is_uc_hex;
        o_cls.digit         = is_dec ? i_char_code[3:0] : (i_char_code[3:0] + 4'd9);
        o_cls.is_prefix     = (i_char_code == ilp_pkg::CHAR_B) ||
                              (i_char_code == ilp_pkg::CHAR_O) ||
                              (i_char_code == ilp_pkg::CHAR_X);
        if (i_char_code == ilp_pkg::CHAR_B) begin
            o_cls.prefix_radix = ilp_pkg::RADIX_BIN;
        end else if (i_char_code == ilp_pkg::CHAR_O) begin
            o_cls.prefix_radix = ilp_pkg::RADIX_OCT;
        end else begin
            o_cls.prefix_radix = ilp_pkg::RADIX_HEX;
        end
        o_cls.suffix_hit = {i_char_code == ilp_pkg::CHAR_2,
                            i_char_code == ilp_pkg::CHAR_3,
                            i_char_code == ilp_pkg::CHAR_I};
    end

endmodule

FILE: hdl/ilp_queue.sv
// ----------------------------------------------------------------------------
// ilp_queue
// Short register queue between the classifying front and the parsing back.
// ----------------------------------------------------------------------------
`include "int_literal_parser_unit_macros.svh"

module ilp_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ilp_pkg::t_cls          i_item,
    output ilp_pkg::t_queue_status o_status,
    input  logic                   i_pop,
    output logic                   o_valid,
    output ilp_pkg::t_cls          o_item
);

    ilp_pkg::t_cls                      r_entry [ilp_pkg::QUEUE_DEPTH];
    logic [ilp_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [ilp_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [ilp_pkg::QUEUE_CNT_W-1:0]    r_count;
    logic [ilp_pkg::QUEUE_CNT_W-1:0]    n_count;

    // Status and head entry
    assign o_status.full = (r_count == ilp_pkg::QUEUE_CNT_W'(ilp_pkg::QUEUE_DEPTH));
    assign o_valid       = (r_count != '0);
    assign o_item        = r_entry[r_rd_ptr];

    // Fill level
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    `ILP_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, i_push, r_count < ilp_pkg::QUEUE_CNT_W'(ilp_pkg::QUEUE_DEPTH))
    `ILP_ASSERT_IMPL(a_pop_has_entry, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

FILE: hdl/ilp_back.sv
// ----------------------------------------------------------------------------
// ilp_back
// Applies one classified character per cycle to the parser state (a last character
// waits while an untaken result is held) and registers the result on the last character of a literal.
// ----------------------------------------------------------------------------
`include "int_literal_parser_unit_macros.svh"

module ilp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  ilp_pkg::t_cls               i_q_item,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ilp_pkg::VALUE_W-1:0] o_value,
    output logic                        o_accepted
);

    // Parser state
    logic [1:0]                  r_radix;
    logic [1:0]                  r_char_index;
    logic                        r_first_was_zero;
    logic [ilp_pkg::VALUE_W-1:0] r_accum;
    logic                        r_saw_digit;
    logic                        r_prev_was_digit;
    logic                        r_pending_underscore;
    logic                        r_in_suffix;
    logic [1:0]                  r_suffix_matched;
    logic                        r_rejected;

    logic [1:0]                  n_radix;
    logic [1:0]                  n_char_index;
    logic                        n_first_was_zero;
    logic [ilp_pkg::VALUE_W-1:0] n_accum;
    logic                        n_saw_digit;
    logic                        n_prev_was_digit;
    logic                        n_pending_underscore;
    logic                        n_in_suffix;
    logic [1:0]                  n_suffix_matched;
    logic                        n_rejected;

    // Output register
    logic                        r_out_valid;
    logic [ilp_pkg::VALUE_W-1:0] r_out_value;
    logic                        r_out_accepted;

    ilp_pkg::t_cls                c;
    logic                         digit_in_base;
    logic                         suffix_hit;
    logic [ilp_pkg::SCALED_W-1:0] scaled;
    logic [ilp_pkg::NEXT_W-1:0]   next_accum;
    logic                         overflow;
    logic                         ok;

    assign c = i_q_item;

    // Take an item unless it would overwrite a result still waiting
    assign o_pop = i_q_valid & (~c.last | ~r_out_valid | ~i_stall);

    // Digit against the current base
    always_comb begin
        unique case (r_radix)
            ilp_pkg::RADIX_DEC: digit_in_base = c.digit_ok && (c.digit <= 4'd9);
            ilp_pkg::RADIX_BIN: digit_in_base = c.digit_ok && (c.digit < 4'd2);
            ilp_pkg::RADIX_OCT: digit_in_base = c.digit_ok && (c.digit < 4'd8);
            default:            digit_in_base = c.digit_ok;
        endcase
    end

    // Next suffix character expected
    always_comb begin
        unique case (r_suffix_matched)
            ilp_pkg::SUFFIX_NONE: suffix_hit = c.suffix_hit[0];
            ilp_pkg::SUFFIX_I:    suffix_hit = c.suffix_hit[1];
            ilp_pkg::SUFFIX_I3:   suffix_hit = c.suffix_hit[2];
            default:              suffix_hit = 1'b0;
        endcase
    end

    // Scale the accumulator by the base with shifts, plus one add for decimal
    always_comb begin
        unique case (r_radix)
            ilp_pkg::RADIX_DEC: scaled = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0};
            ilp_pkg::RADIX_BIN: scaled = {3'b000, r_accum, 1'b0};
            ilp_pkg::RADIX_OCT: scaled = {1'b0, r_accum, 3'b000};
            default:            scaled = {r_accum, 4'b0000};
        endcase
        next_accum = {1'b0, scaled} + ilp_pkg::NEXT_W'(c.digit);
        overflow   = (next_accum[ilp_pkg::NEXT_W-1:ilp_pkg::VALUE_W] != '0);
    end

    // Update the parser state for one character
    always_comb begin
        n_radix              = r_radix;
        n_char_index         = r_char_index;
        n_first_was_zero     = r_first_was_zero;
        n_accum              = r_accum;
        n_saw_digit          = r_saw_digit;
        n_prev_was_digit     = r_prev_was_digit;
        n_pending_underscore = r_pending_underscore;
        n_in_suffix          = r_in_suffix;
        n_suffix_matched     = r_suffix_matched;
        n_rejected           = r_rejected;

        if (c.present) begin
            if (r_char_index != ilp_pkg::CHAR_INDEX_SAT) begin
                n_char_index = r_char_index + 2'd1;
            end
            if (!r_rejected) begin
                if (r_char_index == 2'd1 && r_first_was_zero && c.is_prefix) begin
                    // Radix prefix restarts the digits
                    n_radix          = c.prefix_radix;
                    n_accum          = '0;
                    n_saw_digit      = 1'b0;
                    n_prev_was_digit = 1'b0;
                end else begin
                    if (r_char_index == 2'd0) begin
                        n_first_was_zero = c.is_zero;
                    end
                    if (r_in_suffix) begin
                        if (suffix_hit) begin
                            n_suffix_matched = r_suffix_matched + 2'd1;
                        end else begin
                            n_rejected = 1'b1;
                        end
                    end else if (r_pending_underscore && !digit_in_base) begin
                        // Underscore not followed by a digit
                        n_pending_underscore = 1'b0;
                        n_rejected           = 1'b1;
                    end else begin
                        n_pending_underscore = 1'b0;
                        if (c.is_underscore) begin
                            if (!r_prev_was_digit) begin
                                n_rejected = 1'b1;
                            end else begin
                                n_pending_underscore = 1'b1;
                                n_prev_was_digit     = 1'b0;
                            end
                        end else if (!digit_in_base) begin
                            // Digits end; first suffix character
                            n_in_suffix = 1'b1;
                            if (!r_saw_digit || !r_prev_was_digit || !suffix_hit) begin
                                n_rejected = 1'b1;
                            end else begin
                                n_suffix_matched = r_suffix_matched + 2'd1;
                            end
                        end else if (overflow) begin
                            n_rejected = 1'b1;
                        end else begin
                            n_accum          = next_accum[ilp_pkg::VALUE_W-1:0];
                            n_saw_digit      = 1'b1;
                            n_prev_was_digit = 1'b1;
                        end
                    end
                end
            end
        end

        // Verdict on the updated state
        ok = !n_rejected && n_saw_digit && !n_pending_underscore &&
             (n_in_suffix ? (n_suffix_matched == ilp_pkg::SUFFIX_FULL) : n_prev_was_digit);
    end

    // Advance state; clear it after each literal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix              <= ilp_pkg::RADIX_DEC;
            r_char_index         <= '0;
            r_first_was_zero     <= 1'b0;
            r_accum              <= '0;
            r_saw_digit          <= 1'b0;
            r_prev_was_digit     <= 1'b0;
            r_pending_underscore <= 1'b0;
            r_in_suffix          <= 1'b0;
            r_suffix_matched     <= ilp_pkg::SUFFIX_NONE;
            r_rejected           <= 1'b0;
        end else if (o_pop) begin
            if (c.last) begin
                r_radix              <= ilp_pkg::RADIX_DEC;
                r_char_index         <= '0;
                r_first_was_zero     <= 1'b0;
                r_accum              <= '0;
                r_saw_digit          <= 1'b0;
                r_prev_was_digit     <= 1'b0;
                r_pending_underscore <= 1'b0;
                r_in_suffix          <= 1'b0;
                r_suffix_matched     <= ilp_pkg::SUFFIX_NONE;
                r_rejected           <= 1'b0;
            end else begin
                r_radix              <= n_radix;
                r_char_index         <= n_char_index;
                r_first_was_zero     <= n_first_was_zero;
                r_accum              <= n_accum;
                r_saw_digit          <= n_saw_digit;
                r_prev_was_digit     <= n_prev_was_digit;
                r_pending_underscore <= n_pending_underscore;
                r_in_suffix          <= n_in_suffix;
                r_suffix_matched     <= n_suffix_matched;
                r_rejected           <= n_rejected;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && c.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && c.last) begin
            r_out_value    <= ok ? n_accum : '0;
            r_out_accepted <= ok;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_value    = r_out_value;
    assign o_accepted = r_out_accepted;

    `ILP_ASSERT_IMPL(a_reject_gives_zero, i_clk, i_rst_n, r_out_valid && !r_out_accepted, r_out_value == '0)
    `ILP_ASSERT_NEXT(a_state_cleared, i_clk, i_rst_n, o_pop && c.last, r_char_index == '0 && !r_rejected && r_accum == '0)
    `ILP_ASSERT_IMPL(a_underscore_after_digit, i_clk, i_rst_n, r_pending_underscore, r_saw_digit && !r_prev_was_digit)

endmodule

FILE: hdl/int_literal_parser_unit.sv
// A result is registered at the output after its last character has passed through the queue.
// Throughput: one character per cycle while o_stall is low, set by the back end's
// combinational shift-add-compare update of the accumulator for each character.
// A waiting result holds back only the next last character; the queue then takes one more.
// Reset: synchronous, active low; clears the queue, parser state and output valid.
// ----------------------------------------------------------------------------
// int_literal_parser_unit
// Parses binary, octal, decimal and hex integer literals with underscores and
// an optional i32 suffix, one character per transaction.
// ----------------------------------------------------------------------------
module int_literal_parser_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ilp_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_char_present,
    input  logic                        i_is_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ilp_pkg::VALUE_W-1:0] o_value,
    output logic                        o_accepted
);

    ilp_pkg::t_queue_status queue_status;
    ilp_pkg::t_cls          front_cls;
    ilp_pkg::t_cls          queue_item;
    logic                   push;
    logic                   pop;
    logic                   queue_valid;

    // Classify incoming characters
    ilp_front u_front (
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_char_present (i_char_present),
        .i_is_last      (i_is_last),
        .i_queue_status (queue_status),
        .o_push         (push),
        .o_cls          (front_cls)
    );

    // Decouple front and back
    ilp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_cls),
        .o_status (queue_status),
        .i_pop    (pop),
        .o_valid  (queue_valid),
        .o_item   (queue_item)
    );

    // Parse and deliver results
    ilp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (queue_valid),
        .i_q_item   (queue_item),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_value    (o_value),
        .o_accepted (o_accepted)
    );

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for int_literal_parser_unit
// Sends integer literals one character per transaction and checks each
// value/accepted result against a cycle-free parser model kept in step with the
// accepted characters, or a pinned typed answer. A short table of literals comes
// first, then random well-formed and damaged literals under random idling and stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAR_TARGET  = 1200;  // random characters to send
    localparam int QUIET_LIMIT  = 1000;  // cycles with no transaction before giving up
    localparam int TAIL_CYCLES  = 8;
    localparam int IDLE_PCT     = 22;
    localparam logic [63:0] I32_MAX = 64'h7FFF_FFFF;

    localparam logic [7:0] SUFFIX_TEXT [3] =
        '{ilp_pkg::CHAR_I, ilp_pkg::CHAR_3, ilp_pkg::CHAR_2};
    localparam logic [7:0] TRICKY_CHARS [8] =
        '{ilp_pkg::CHAR_ZERO, ilp_pkg::CHAR_UNDERSCORE, ilp_pkg::CHAR_B, ilp_pkg::CHAR_O,
          ilp_pkg::CHAR_X, ilp_pkg::CHAR_I, ilp_pkg::CHAR_3, ilp_pkg::CHAR_2};

    typedef struct packed {
        logic [ilp_pkg::VALUE_W-1:0] value;
        logic                        accepted;
    } t_literal_result;

    typedef struct packed {
        logic               pinned;
        t_literal_result    result;
    } t_typed_answer;

    typedef struct packed {
        logic [1:0]                  radix;
        logic [1:0]                  pos;
        logic                        lead_zero;
        logic [ilp_pkg::VALUE_W-1:0] acc;
        logic                        any_digit;
        logic                        after_digit;
        logic                        open_underscore;
        logic                        in_suffix;
        logic [1:0]                  suffix_cnt;
        logic                        bad;
    } t_parse_state;

    typedef struct {
        string                       text;
        bit                          gap;      // put a character-less transaction mid-literal
        bit                          pinned;
        logic [ilp_pkg::VALUE_W-1:0] value;
        bit                          accepted;
    } t_literal_row;

    // Directed literals; typed answers only where they are obvious
    t_literal_row literal_rows [9] = '{
        '{"",           1'b0, 1'b1, 31'd0,          1'b0},  // empty literal
        '{"0",          1'b0, 1'b1, 31'd0,          1'b1},
        '{"0x7fffffff", 1'b0, 1'b1, 31'h7FFF_FFFF,  1'b1},  // largest value
        '{"0x80000000", 1'b0, 1'b1, 31'd0,          1'b0},  // overflow
        '{"1_2",        1'b1, 1'b0, 31'd0,          1'b0},
        '{"0b",         1'b0, 1'b1, 31'd0,          1'b0},  // prefix with no digits
        '{"_1",         1'b0, 1'b1, 31'd0,          1'b0},  // leading underscore
        '{"7i32",       1'b0, 1'b0, 31'd0,          1'b0},
        '{"\3779",      1'b0, 1'b1, 31'd0,          1'b0}   // non-ASCII, then ignored
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [ilp_pkg::CHAR_W-1:0]  i_char_code;
    logic                        i_char_present;
    logic                        i_is_last;
    logic                        o_valid;
    logic                        i_stall;
    logic [ilp_pkg::VALUE_W-1:0] o_value;
    logic                        o_accepted;

    t_parse_state    lit_state;
    t_literal_result expected_literals [$];
    t_typed_answer   typed_answers [$];
    logic [7:0]      lit_chars [$];
    int              error_count = 0;
    int              chars_sent  = 0;
    int              idle_pct    = IDLE_PCT;
    int              stall_pct   = IDLE_PCT;

    int_literal_parser_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_char_present (i_char_present),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_value        (o_value),
        .o_accepted     (o_accepted)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int radix_base(logic [1:0] radix);
        case (radix)
            ilp_pkg::RADIX_BIN: return 2;
            ilp_pkg::RADIX_OCT: return 8;
            ilp_pkg::RADIX_HEX: return 16;
            default:            return 10;
        endcase
    endfunction

    function automatic void match_suffix(logic [7:0] c);
        if (lit_state.suffix_cnt < ilp_pkg::SUFFIX_FULL &&
            c == SUFFIX_TEXT[lit_state.suffix_cnt]) begin
            lit_state.suffix_cnt = lit_state.suffix_cnt + 2'd1;
        end else begin
            lit_state.bad = 1'b1;
        end
    endfunction

    // Advance the parser by one transaction; returns 1 when a result is due
    function automatic bit parse_step(input logic [7:0] c, input logic present,
                                      input logic last, output t_literal_result res);
        logic [1:0]  pos;
        int          base;
        int          d;
        bit          ok;
        bit          good;
        logic [63:0] nxt;
        res = '0;
        if (present) begin
            pos = lit_state.pos;
            if (lit_state.pos < ilp_pkg::CHAR_INDEX_SAT)
                lit_state.pos = lit_state.pos + 2'd1;
            if (!lit_state.bad) begin
                if (pos == 2'd1 && lit_state.lead_zero &&
                    (c == ilp_pkg::CHAR_B || c == ilp_pkg::CHAR_O ||
                     c == ilp_pkg::CHAR_X)) begin
                    // radix prefix restarts the digits
                    lit_state.radix = (c == ilp_pkg::CHAR_B) ? ilp_pkg::RADIX_BIN :
                                      (c == ilp_pkg::CHAR_O) ? ilp_pkg::RADIX_OCT :
                                                               ilp_pkg::RADIX_HEX;
                    lit_state.acc = '0;
                    lit_state.any_digit = 1'b0;
                    lit_state.after_digit = 1'b0;
                end else begin
                    if (pos == 2'd0)
                        lit_state.lead_zero = (c == ilp_pkg::CHAR_ZERO);
                    if (lit_state.in_suffix) begin
                        match_suffix(c);
                    end else begin
                        base = radix_base(lit_state.radix);
                        if (c >= ilp_pkg::CHAR_ZERO && c <= ilp_pkg::CHAR_NINE)
                            d = int'(c - ilp_pkg::CHAR_ZERO);
                        else if (c >= ilp_pkg::CHAR_LC_A && c <= ilp_pkg::CHAR_LC_F)
                            d = int'(c - ilp_pkg::CHAR_LC_A) + 10;
                        else if (c >= ilp_pkg::CHAR_UC_A && c <= ilp_pkg::CHAR_UC_F)
                            d = int'(c - ilp_pkg::CHAR_UC_A) + 10;
                        else
                            d = -1;
                        ok = (d >= 0) && (d < base);
                        // an underscore must be followed by a digit
                        if (lit_state.open_underscore) begin
                            lit_state.open_underscore = 1'b0;
                            if (!ok)
                                lit_state.bad = 1'b1;
                        end
                        if (!lit_state.bad) begin
                            if (c == ilp_pkg::CHAR_UNDERSCORE) begin
                                if (!lit_state.after_digit) begin
                                    lit_state.bad = 1'b1;
                                end else begin
                                    lit_state.open_underscore = 1'b1;
                                    lit_state.after_digit = 1'b0;
                                end
                            end else if (!ok) begin
                                // first non-digit opens the suffix
                                lit_state.in_suffix = 1'b1;
                                if (!lit_state.any_digit || !lit_state.after_digit)
                                    lit_state.bad = 1'b1;
                                else
                                    match_suffix(c);
                            end else begin
                                nxt = 64'(lit_state.acc) * 64'(base) + 64'(d);
                                if (nxt > I32_MAX) begin
                                    lit_state.bad = 1'b1;
                                end else begin
                                    lit_state.acc = nxt[ilp_pkg::VALUE_W-1:0];
                                    lit_state.any_digit = 1'b1;
                                    lit_state.after_digit = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
        end
        if (last) begin
            good = !lit_state.bad && lit_state.any_digit && !lit_state.open_underscore;
            if (good)
                good = lit_state.in_suffix ? (lit_state.suffix_cnt == ilp_pkg::SUFFIX_FULL)
                                           : lit_state.after_digit;
            res.value = good ? lit_state.acc : '0;
            res.accepted = good;
            lit_state = '0;
        end
        return last;
    endfunction

    // Predict on accepted input, check on accepted output
    always @(posedge i_clk) begin : scoreboard
        t_literal_result want;
        t_literal_result predicted;
        t_typed_answer   typed;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_literals.size() == 0) begin
                    $display("%0t: result with none expected: value %0d accepted %0b",
                             $time, o_value, o_accepted);
                    error_count++;
                end else begin
                    want = expected_literals.pop_front();
                    if (o_value !== want.value) begin
                        $display("%0t: value mismatch: expected %0d actual %0d",
                                 $time, want.value, o_value);
                        error_count++;
                    end
                    if (o_accepted !== want.accepted) begin
                        $display("%0t: accepted mismatch: expected %0b actual %0b",
                                 $time, want.accepted, o_accepted);
                        error_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                if (parse_step(i_char_code, i_char_present, i_is_last, predicted)) begin
                    if (typed_answers.size() != 0) begin
                        typed = typed_answers.pop_front();
                        expected_literals.insert(expected_literals.size(),
                                                 typed.pinned ? typed.result : predicted);
                    end else begin
                        expected_literals.insert(expected_literals.size(), predicted);
                    end
                end
            end
        end
    end

    // Result side: random stalls
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Give up when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // Drive one transaction, with random idle cycles ahead of it
    task automatic send_item(input logic [7:0] c, input logic present, input logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= c;
        i_char_present <= present;
        i_is_last <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Send lit_chars as one literal; an empty queue is the empty literal
    task automatic send_literal(input bit force_gap);
        int n;
        n = lit_chars.size();
        if (n == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            chars_sent++;
        end
        for (int k = 0; k < n; k++) begin
            if (k > 0 && ((force_gap && k == 1) || $urandom_range(0, 19) == 0))
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(lit_chars[k], 1'b1, k == n - 1);
            chars_sent++;
        end
    endtask

    // Hold off the input until every pending result has come back
    task automatic hold_until_answered();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_literals.size() != 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Build a well-formed literal into lit_chars, then damage it if asked
    task automatic compose_literal(input bit damaged);
        logic [1:0]  radix;
        logic [31:0] target;
        int          base;
        int          digs [$];
        int          idx;
        lit_chars.delete();
        radix = 2'($urandom_range(0, 3));
        base = radix_base(radix);
        if (radix != ilp_pkg::RADIX_DEC) begin
            lit_chars.insert(lit_chars.size(), ilp_pkg::CHAR_ZERO);
            lit_chars.insert(lit_chars.size(),
                             radix == ilp_pkg::RADIX_BIN ? ilp_pkg::CHAR_B :
                             radix == ilp_pkg::RADIX_OCT ? ilp_pkg::CHAR_O :
                                                           ilp_pkg::CHAR_X);
        end
        // short literals mostly; some aimed at the top of the range
        if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(1, 4))
                digs.insert(digs.size(), $urandom_range(0, base - 1));
        end else begin
            case ($urandom_range(0, 3))
                0:       target = 32'h7FFF_FFFF;
                1:       target = 32'h8000_0000;
                2:       target = $urandom;
                default: target = $urandom >> $urandom_range(1, 31);
            endcase
            do begin
                digs.push_front(int'(target % base));
                target = target / base;
            end while (target != 0);
        end
        foreach (digs[k]) begin
            if (k > 0 && $urandom_range(0, 5) == 0)
                lit_chars.insert(lit_chars.size(), ilp_pkg::CHAR_UNDERSCORE);
            if (digs[k] < 10)
                lit_chars.insert(lit_chars.size(), ilp_pkg::CHAR_ZERO + 8'(digs[k]));
            else
                lit_chars.insert(lit_chars.size(),
                                 ($urandom_range(0, 1) ? ilp_pkg::CHAR_LC_A :
                                                         ilp_pkg::CHAR_UC_A)
                                 + 8'(digs[k] - 10));
        end
        if ($urandom_range(0, 2) == 0) begin
            foreach (SUFFIX_TEXT[k])
                lit_chars.insert(lit_chars.size(), SUFFIX_TEXT[k]);
        end
        if (damaged) begin
            idx = $urandom_range(0, lit_chars.size() - 1);
            case ($urandom_range(0, 4))
                0: lit_chars[idx] = 8'($urandom_range(0, 255));
                1: lit_chars.insert(idx, ilp_pkg::CHAR_UNDERSCORE);
                2: if (lit_chars.size() > 1) lit_chars.delete(idx);
                3: lit_chars.insert(lit_chars.size(), TRICKY_CHARS[$urandom_range(0, 7)]);
                default: begin
                    // plain noise
                    lit_chars.delete();
                    repeat ($urandom_range(1, 5))
                        lit_chars.insert(lit_chars.size(),
                                         $urandom_range(0, 1) ?
                                         TRICKY_CHARS[$urandom_range(0, 7)] :
                                         8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // Main sequence
    initial begin
        int            lit_count;
        int            pick;
        t_typed_answer row_answer;
        lit_state = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_char_code = '0;
        i_char_present = 1'b0;
        i_is_last = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed literals
        foreach (literal_rows[r]) begin
            lit_chars.delete();
            for (int k = 0; k < literal_rows[r].text.len(); k++)
                lit_chars.insert(lit_chars.size(), literal_rows[r].text[k]);
            row_answer = '{literal_rows[r].pinned,
                           '{literal_rows[r].value, literal_rows[r].accepted}};
            typed_answers.insert(typed_answers.size(), row_answer);
            send_literal(literal_rows[r].gap);
        end
        hold_until_answered();

        // Random literals
        chars_sent = 0;
        lit_count = 0;
        while (chars_sent < CHAR_TARGET) begin
            // a calm stretch with no idling on either side
            idle_pct  = (lit_count >= 150 && lit_count < 250) ? 0 : IDLE_PCT;
            stall_pct = idle_pct;
            if (lit_count % 50 == 49)
                hold_until_answered();
            pick = $urandom_range(0, 99);
            if (pick < 3)
                lit_chars.delete();
            else
                compose_literal(pick >= 78);
            send_literal(1'b0);
            lit_count++;
        end

        // Drain and finish
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_literals.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
